### design/apa_pkg.sv
// apa_pkg: constants, defaults and the cordic angle table for the pitch angle block
// no dependencies; used by accel_pitch_angle, apa_front and apa_back
`default_nettype none

package apa_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;

    // fixed working widths (independent of sample bits since the scale is 31 - sample bits)
    localparam int ROOT_W = 31;   // integer square root width
    localparam int REM_W  = 35;   // square root remainder width
    localparam int NUM_W  = 62;   // scaled sum of squares width
    localparam int VEC_W  = 35;   // cordic x/y width
    localparam int ACC_W  = 26;   // angle accumulator, 2^-16 degree
    localparam int OUT_W  = 16;

    localparam logic signed [OUT_W-1:0] LIMIT_90 = 16'sd23040;

    // round(atan(2^-i) * 180/pi * 2^16)
    function automatic logic [ACC_W-1:0] atan_step(input int i);
        logic [ACC_W-1:0] v;
        case (i)
            0:  v = 26'd2949120;
            1:  v = 26'd1740967;
            2:  v = 26'd919879;
            3:  v = 26'd475137;
            4:  v = 26'd234379;
            5:  v = 26'd117304;
            6:  v = 26'd58666;
            7:  v = 26'd29335;
            8:  v = 26'd14668;
            9:  v = 26'd7334;
            10: v = 26'd3667;
            11: v = 26'd1833;
            12: v = 26'd917;
            13: v = 26'd458;
            14: v = 26'd229;
            15: v = 26'd115;
            16: v = 26'd57;
            17: v = 26'd29;
            18: v = 26'd14;
            19: v = 26'd7;
            20: v = 26'd4;
            21: v = 26'd2;
            22: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/accel_pitch_angle.sv
// accel_pitch_angle: top level, pitch angle of a three-axis accelerometer sample
// depends on apa_pkg, apa_front, apa_queue, apa_back
`default_nettype none

// channel   dir   handshake          contents
// s_axis    in    s_tvalid/tready    s_tdata: accel_x, accel_y, accel_z
// m_axis    out   m_tvalid/tready    m_tdata: pitch_deg, 1/256 degree
//
// one word per cycle sustained while m_tready holds; after the accepting edge a
// word passes the front register, the queue, the back entry register,
// 31 square root stages (one root bit each), CORDIC_STEPS cordic stages and
// one output register before m_tvalid rises
// reset clears only valid bits, queue pointers and queue count; no state between words
// a stall on m_tready freezes the back pipeline; the two-entry queue lets the
// front keep taking words until it fills

module accel_pitch_angle #(
    parameter int CORDIC_STEPS = apa_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = apa_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // pitch_deg [15:0]
);
    localparam int IW = 7 * SAMPLE_BITS;

    logic          f_vld, f_rdy, q_vld, q_rdy, en;
    logic [IW-1:0] f_item, q_item;

    // back pipeline advances whenever the output register can move
    assign en    = !m_tvalid || m_tready;
    assign q_rdy = en;

    apa_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_tvalid),
        .in_rdy   (s_tready),
        .in_x     (s_tdata[15:0]),
        .in_y     (s_tdata[31:16]),
        .in_z     (s_tdata[47:32]),
        .out_vld  (f_vld),
        .out_rdy  (f_rdy),
        .out_item (f_item)
    );

    apa_queue #(.WIDTH(IW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (f_vld),
        .push_rdy  (f_rdy),
        .push_data (f_item),
        .pop_vld   (q_vld),
        .pop_rdy   (q_rdy),
        .pop_data  (q_item)
    );

    apa_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (q_vld),
        .in_item   (q_item),
        .out_vld   (m_tvalid),
        .out_pitch (m_tdata)
    );

    // result always within plus or minus ninety degrees
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= apa_pkg::LIMIT_90 &&
                      $signed(m_tdata) >= -apa_pkg::LIMIT_90))
        else $error("pitch out of range");

    // a stalled output word is not overwritten by the pipeline
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");

    // a valid output word carries no unknown bits
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown(m_tdata))
        else $error("output word has unknown bits");

endmodule

`default_nettype wire

### design/apa_front.sv
// apa_front: takes a sample word, zero-fills the axes above bit 15 and squares y and z
// depends on apa_pkg
`default_nettype none

module apa_front #(
    parameter int SAMPLE_BITS = apa_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_vld,
    output logic                             in_rdy,
    input  wire logic [15:0]                 in_x,
    input  wire logic [15:0]                 in_y,
    input  wire logic [15:0]                 in_z,
    output logic                             out_vld,
    input  wire logic                        out_rdy,
    output logic [3*SAMPLE_BITS+4*SAMPLE_BITS-1:0] out_item
);
    localparam int SB = SAMPLE_BITS;
    localparam int SW = 2 * SB;

    logic                 vld_reg;
    logic signed [SB-1:0] ax, ay, az;
    logic signed [SW-1:0] ysq, zsq;
    logic signed [SB-1:0] ax_reg;
    logic [SW-1:0]        ysq_reg, zsq_reg;
    logic                 take;

    always_comb
    begin
        for (int b = 0; b < SB; b++)
        begin
            ax[b] = (b < 16) ? in_x[b % 16] : 1'b0;
            ay[b] = (b < 16) ? in_y[b % 16] : 1'b0;
            az[b] = (b < 16) ? in_z[b % 16] : 1'b0;
        end
    end

    // full-width signed squares
    assign ysq = ay * ay;
    assign zsq = az * az;

    assign in_rdy = !vld_reg || out_rdy;
    assign take   = in_vld && in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_rdy)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ax_reg  <= ax;
            ysq_reg <= $unsigned(ysq);
            zsq_reg <= $unsigned(zsq);
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = {zsq_reg, ysq_reg, SB'(0), SB'(0), ax_reg};

endmodule

`default_nettype wire

### design/apa_queue.sv
// apa_queue: two-entry fifo between the front and back parts
// depends on apa_pkg only through its users
`default_nettype none

module apa_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_vld,
    output logic                  push_rdy,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_vld,
    input  wire logic             pop_rdy,
    output logic [WIDTH-1:0]      pop_data
);
    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign push_rdy = (cnt_reg != 2'd2);
    assign pop_vld  = (cnt_reg != 2'd0);
    assign push     = push_vld && push_rdy;
    assign pop      = pop_vld && pop_rdy;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");

endmodule

`default_nettype wire

### design/apa_back.sv
// apa_back: pipelined integer square root followed by a pipelined vectoring cordic
// depends on apa_pkg
`default_nettype none

module apa_back #(
    parameter int SAMPLE_BITS  = apa_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = apa_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic [7*SAMPLE_BITS-1:0]      in_item,
    output logic                               out_vld,
    output logic [apa_pkg::OUT_W-1:0]          out_pitch
);
    localparam int SB  = SAMPLE_BITS;
    localparam int SW  = 2 * SB;
    localparam int S   = 31 - SB;
    localparam int RT  = apa_pkg::ROOT_W;
    localparam int RW  = apa_pkg::REM_W;
    localparam int NW  = apa_pkg::NUM_W;
    localparam int CW  = apa_pkg::VEC_W;
    localparam int AW  = apa_pkg::ACC_W;
    localparam int OW  = apa_pkg::OUT_W;
    localparam int QW  = AW - 8;

    logic signed [SB-1:0] in_ax;
    logic [SW-1:0]        in_ysq, in_zsq, in_sum;
    logic signed [CW-1:0] in_cy;
    logic signed [OW-1:0] in_sval;

    assign in_ax  = $signed(in_item[SB-1:0]);
    assign in_ysq = in_item[3*SB +: SW];
    assign in_zsq = in_item[5*SB +: SW];
    assign in_sum = in_ysq + in_zsq;
    assign in_cy  = -($signed(CW'(in_ax)) <<< S);

    always_comb
    begin
        if (in_ax > 0)
            in_sval = -apa_pkg::LIMIT_90;
        else if (in_ax < 0)
            in_sval = apa_pkg::LIMIT_90;
        else
            in_sval = '0;
    end

    // square root stages, index 0 is the entry register
    logic                 sq_vld_reg  [0:RT];
    logic [SW-1:0]        sq_sum_reg  [0:RT];
    logic [RW-1:0]        sq_rem_reg  [0:RT];
    logic [RT-1:0]        sq_root_reg [0:RT];
    logic signed [CW-1:0] sq_cy_reg   [0:RT];
    logic                 sq_spec_reg [0:RT];
    logic signed [OW-1:0] sq_sval_reg [0:RT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (en)
            sq_vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_sum_reg[0]  <= in_sum;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_cy_reg[0]   <= in_cy;
            sq_spec_reg[0] <= (in_sum == '0);
            sq_sval_reg[0] <= in_sval;
        end
    end

    for (genvar j = 0; j < RT; j++)
    begin : g_sqrt
        logic [NW-1:0] num;
        logic [RW-1:0] r2, trial;
        logic          fit;

        assign num   = {sq_sum_reg[j], {(NW-SW){1'b0}}};
        assign r2    = {sq_rem_reg[j][RW-3:0], num[NW-1-2*j -: 2]};
        assign trial = RW'({sq_root_reg[j], 2'b01});
        assign fit   = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[j+1] <= 1'b0;
            else if (en)
                sq_vld_reg[j+1] <= sq_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_sum_reg[j+1]  <= sq_sum_reg[j];
                sq_rem_reg[j+1]  <= fit ? (r2 - trial) : r2;
                sq_root_reg[j+1] <= {sq_root_reg[j][RT-2:0], fit};
                sq_cy_reg[j+1]   <= sq_cy_reg[j];
                sq_spec_reg[j+1] <= sq_spec_reg[j];
                sq_sval_reg[j+1] <= sq_sval_reg[j];
            end
        end
    end

    // cordic stages, index 0 is the last square root stage
    logic                 cd_vld  [0:CORDIC_STEPS];
    logic signed [CW-1:0] cd_cx   [0:CORDIC_STEPS];
    logic signed [CW-1:0] cd_cy   [0:CORDIC_STEPS];
    logic signed [AW-1:0] cd_acc  [0:CORDIC_STEPS];
    logic                 cd_spec [0:CORDIC_STEPS];
    logic signed [OW-1:0] cd_sval [0:CORDIC_STEPS];

    assign cd_vld[0]  = sq_vld_reg[RT];
    assign cd_cx[0]   = $signed(CW'(sq_root_reg[RT]));
    assign cd_cy[0]   = sq_cy_reg[RT];
    assign cd_acc[0]  = '0;
    assign cd_spec[0] = sq_spec_reg[RT];
    assign cd_sval[0] = sq_sval_reg[RT];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic                 vld_reg, spec_reg;
        logic signed [CW-1:0] cx_reg, cy_reg, dx, dy;
        logic signed [AW-1:0] acc_reg, ang;
        logic signed [OW-1:0] sval_reg;

        assign dx  = cd_cy[i] >>> i;
        assign dy  = cd_cx[i] >>> i;
        assign ang = $signed(apa_pkg::atan_step(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= cd_vld[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cd_cy[i][CW-1])
                begin
                    cx_reg  <= cd_cx[i] + dx;
                    cy_reg  <= cd_cy[i] - dy;
                    acc_reg <= cd_acc[i] + ang;
                end
                else
                begin
                    cx_reg  <= cd_cx[i] - dx;
                    cy_reg  <= cd_cy[i] + dy;
                    acc_reg <= cd_acc[i] - ang;
                end
                spec_reg <= cd_spec[i];
                sval_reg <= cd_sval[i];
            end
        end

        assign cd_vld[i+1]  = vld_reg;
        assign cd_cx[i+1]   = cx_reg;
        assign cd_cy[i+1]   = cy_reg;
        assign cd_acc[i+1]  = acc_reg;
        assign cd_spec[i+1] = spec_reg;
        assign cd_sval[i+1] = sval_reg;
    end

    // round half up to 1/256 degree and clamp, or use the preset value when y and z are both zero
    logic signed [AW-1:0] acc_rnd;
    logic signed [QW-1:0] q;
    logic signed [OW-1:0] res;
    logic                 out_vld_reg;
    logic [OW-1:0]        out_pitch_reg;

    assign acc_rnd = cd_acc[CORDIC_STEPS] + AW'(128);
    assign q       = QW'(acc_rnd >>> 8);

    always_comb
    begin
        if (cd_spec[CORDIC_STEPS])
            res = cd_sval[CORDIC_STEPS];
        else if (q > QW'(apa_pkg::LIMIT_90))
            res = apa_pkg::LIMIT_90;
        else if (q < -QW'(apa_pkg::LIMIT_90))
            res = -apa_pkg::LIMIT_90;
        else
            res = OW'(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= cd_vld[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_pitch_reg <= res;
    end

    assign out_vld   = out_vld_reg;
    assign out_pitch = out_pitch_reg;

endmodule

`default_nettype wire
